/* sv/swmts_pkg.sv */
// ----------------------------------------------------------------------------
// swmts_pkg
// Shared types, constants and the wrapping span test for the schedule window
// minutes-to-start block.
// ----------------------------------------------------------------------------
package swmts_pkg;

  localparam int DATE_W   = 21;   // packed year/month/mday position
  localparam int DATER_W  = 23;   // signed date span result
  localparam int SPAN_W   = 24;   // working width of the span test
  localparam int MINC_W   = 11;   // packed hour/minute position
  localparam int DAYR_W   = 5;    // signed weekday span result
  localparam int MINR_W   = 13;   // signed minute span result
  localparam int MDIF_W   = 12;   // signed minute differences
  localparam int OUT_W    = 32;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  localparam int MONTHS_PER_YEAR  = 12;
  localparam int MDAYS_PER_MONTH  = 31;
  localparam int MINUTES_PER_HOUR = 60;
  localparam int MINUTES_PER_DAY  = 1440;

  localparam logic signed [SPAN_W-1:0] DAY_SPAN     = 24'sd1116000;
  localparam logic signed [SPAN_W-1:0] MIN_PER_DAY  = 24'sd1440;
  localparam logic signed [SPAN_W-1:0] WEEK_SPAN    = 24'sd7;

  localparam logic signed [SPAN_W-1:0] SPAN_INSIDE   = 24'sd0;
  localparam logic signed [SPAN_W-1:0] SPAN_AT_START = -24'sd1;
  localparam logic signed [SPAN_W-1:0] SPAN_AT_STOP  = -24'sd2;
  localparam logic signed [SPAN_W-1:0] SPAN_AT_BOTH  = -24'sd3;
  localparam logic signed [SPAN_W-1:0] NO_CHECK      = -24'sd4;
  localparam logic signed [SPAN_W-1:0] SPAN_ANY      = -24'sd1;

  localparam logic [2:0] REG_START_DATE  = 3'd0;
  localparam logic [2:0] REG_START_CLOCK = 3'd1;
  localparam logic [2:0] REG_STOP_DATE   = 3'd2;
  localparam logic [2:0] REG_STOP_CLOCK  = 3'd3;
  localparam logic [2:0] REG_CONTINUED   = 3'd4;

  localparam logic [23:0] DATE_RESET  = 24'hE00000;
  localparam logic [16:0] CLOCK_RESET = 17'h1C000;

  typedef struct packed {
    logic [23:0] start_date;
    logic [16:0] start_clock;
    logic [23:0] stop_date;
    logic [16:0] stop_clock;
    logic        continued_mode;
  } cfg_t;

  typedef struct packed {
    logic                     date_used;
    logic [DATE_W-1:0]        da;
    logic [DATE_W-1:0]        db;
    logic [DATE_W-1:0]        dn;
    logic signed [DAYR_W-1:0] day_r;
    logic                     week_both;
    logic                     min_used;
    logic [MINC_W-1:0]        ma;
    logic [MINC_W-1:0]        mb;
    logic [MINC_W-1:0]        mn;
    logic                     cd_start_hit;
    logic                     cd_stop_hit;
  } s1_t;

  typedef struct packed {
    logic signed [DATER_W-1:0] date_r;
    logic signed [DAYR_W-1:0]  day_r;
    logic                      week_both;
    logic                      min_used;
    logic signed [MINR_W-1:0]  min_r;
    logic signed [MINR_W-1:0]  min_r2;
    logic                      ab_eq;
    logic                      ab_lt;
    logic                      n_lt_a;
    logic                      n_gt_b;
    logic signed [MDIF_W-1:0]  a_minus_b;
    logic signed [MDIF_W-1:0]  tail;
    logic                      cd_start_hit;
    logic                      cd_stop_hit;
  } s2_t;

  // Position n against a span from s to e that wraps at m.
  function automatic logic signed [SPAN_W-1:0] span_test(
    input logic signed [SPAN_W-1:0] s,
    input logic signed [SPAN_W-1:0] e,
    input logic signed [SPAN_W-1:0] n,
    input logic signed [SPAN_W-1:0] m
  );
    logic signed [SPAN_W-1:0] r;
    if (s == n && e == n) begin
      r = SPAN_AT_BOTH;
    end else if (s == n) begin
      r = SPAN_AT_START;
    end else if (e == n) begin
      r = SPAN_AT_STOP;
    end else if (s < SPAN_INSIDE || e < SPAN_INSIDE) begin
      r = SPAN_INSIDE;
    end else if (s < e) begin
      if (s < n && e > n) begin
        r = SPAN_INSIDE;
      end else if (s < n && e < n) begin
        r = m - n + s;
      end else begin
        r = s - n;
      end
    end else if (s > e) begin
      if (s > n && e > n) begin
        r = SPAN_INSIDE;
      end else if (s > n && e < n) begin
        r = s - n;
      end else begin
        r = SPAN_INSIDE;
      end
    end else if (s < n) begin
      r = m - n + s;
    end else begin
      r = s - n;
    end
    return r;
  endfunction

endpackage

/* sv/schedule_window_minutes_to_start.sv */
// ----------------------------------------------------------------------------
// schedule_window_minutes_to_start
// Path: an accepted item passes the prep, span and resolve stage registers to out_valid.
// Throughput: one item per cycle while out_stall is low; set by the three-stage compute pipeline.
// Reset: rst_n clears all stage valids and loads the register reset values.
// ----------------------------------------------------------------------------
module schedule_window_minutes_to_start import swmts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [PADDR_W-1:0]      cfg_paddr,
  input  logic [PDATA_W-1:0]      cfg_pwdata,
  output logic [PDATA_W-1:0]      cfg_prdata,
  output logic                    cfg_pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [11:0]             in_now_year,
  input  logic [3:0]              in_now_month,
  input  logic [4:0]              in_now_mday,
  input  logic [2:0]              in_now_wday,
  input  logic [4:0]              in_now_hour,
  input  logic [5:0]              in_now_minute,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_minutes_to_start
);

  cfg_t cfg;
  s1_t  s1_data;
  s2_t  s2_data;
  logic s1_valid, s2_valid, s3_valid;
  logic s1_en, s2_en, s3_en;

  // Advance a stage when it is empty or the next one moves
  assign s3_en    = !s3_valid || !out_stall;
  assign s2_en    = !s2_valid || s3_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;

  swmts_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  swmts_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (s1_en),
    .valid_in   (in_valid),
    .cfg        (cfg),
    .now_year   (in_now_year),
    .now_month  (in_now_month),
    .now_mday   (in_now_mday),
    .now_wday   (in_now_wday),
    .now_hour   (in_now_hour),
    .now_minute (in_now_minute),
    .valid_r    (s1_valid),
    .data_r     (s1_data)
  );

  swmts_span u_span (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (s2_en),
    .valid_in (s1_valid),
    .data_in  (s1_data),
    .valid_r  (s2_valid),
    .data_r   (s2_data)
  );

  swmts_resolve u_resolve (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (s3_en),
    .valid_in       (s2_valid),
    .data_in        (s2_data),
    .continued_mode (cfg.continued_mode),
    .valid_r        (s3_valid),
    .result_r       (out_minutes_to_start)
  );

  assign out_valid = s3_valid;

endmodule

/* sv/swmts_cfg.sv */
// ----------------------------------------------------------------------------
// swmts_cfg
// APB register file holding the window start/stop points and the mode bit.
// ----------------------------------------------------------------------------
module swmts_cfg import swmts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready,
  output cfg_t               cfg
);

  logic [23:0] start_date_r;
  logic [16:0] start_clock_r;
  logic [23:0] stop_date_r;
  logic [16:0] stop_clock_r;
  logic        continued_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_date_r  <= DATE_RESET;
      start_clock_r <= CLOCK_RESET;
      stop_date_r   <= DATE_RESET;
      stop_clock_r  <= CLOCK_RESET;
      continued_r   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_DATE:  start_date_r  <= cfg_pwdata[23:0];
        REG_START_CLOCK: start_clock_r <= cfg_pwdata[16:0];
        REG_STOP_DATE:   stop_date_r   <= cfg_pwdata[23:0];
        REG_STOP_CLOCK:  stop_clock_r  <= cfg_pwdata[16:0];
        REG_CONTINUED:   continued_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_DATE:  cfg_prdata = PDATA_W'(start_date_r);
      REG_START_CLOCK: cfg_prdata = PDATA_W'(start_clock_r);
      REG_STOP_DATE:   cfg_prdata = PDATA_W'(stop_date_r);
      REG_STOP_CLOCK:  cfg_prdata = PDATA_W'(stop_clock_r);
      REG_CONTINUED:   cfg_prdata = PDATA_W'(continued_r);
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.start_date     = start_date_r;
  assign cfg.start_clock    = start_clock_r;
  assign cfg.stop_date      = stop_date_r;
  assign cfg.stop_clock     = stop_clock_r;
  assign cfg.continued_mode = continued_r;

endmodule

/* sv/swmts_prep.sv */
// ----------------------------------------------------------------------------
// swmts_prep
// Stage 1: decode wildcards, pack date and clock positions, test the weekday
// span and the continued-mode start/stop clock compares.
// ----------------------------------------------------------------------------
module swmts_prep import swmts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        valid_in,
  input  cfg_t        cfg,
  input  logic [11:0] now_year,
  input  logic [3:0]  now_month,
  input  logic [4:0]  now_mday,
  input  logic [2:0]  now_wday,
  input  logic [4:0]  now_hour,
  input  logic [5:0]  now_minute,
  output logic        valid_r,
  output s1_t         data_r
);

  logic [11:0] yr_s, yr_e;
  logic [3:0]  mo_s, mo_e;
  logic [4:0]  md_s, md_e;
  logic [2:0]  wd_s, wd_e;
  logic [4:0]  hr_s, hr_e;
  logic [5:0]  mi_s, mi_e;
  logic        fw_s, fw_e, fh_s, fh_e, fn_s, fn_e;
  logic        use_y, use_m, use_d, use_h, use_n;
  logic [15:0] a12_s, a12_e, n12;
  logic signed [SPAN_W-1:0] sw, ew, day_full;
  logic [4:0]  hs_a, hs_n, he_a, he_n;
  logic [MINC_W-1:0] cs_a, cs_n, ce_a, ce_n;
  s1_t         data_nxt;

  assign yr_s = cfg.start_date[11:0];
  assign mo_s = cfg.start_date[15:12];
  assign md_s = cfg.start_date[20:16];
  assign yr_e = cfg.stop_date[11:0];
  assign mo_e = cfg.stop_date[15:12];
  assign md_e = cfg.stop_date[20:16];
  assign wd_s = cfg.start_clock[2:0];
  assign hr_s = cfg.start_clock[7:3];
  assign mi_s = cfg.start_clock[13:8];
  assign fw_s = cfg.start_clock[14];
  assign fh_s = cfg.start_clock[15];
  assign fn_s = cfg.start_clock[16];
  assign wd_e = cfg.stop_clock[2:0];
  assign hr_e = cfg.stop_clock[7:3];
  assign mi_e = cfg.stop_clock[13:8];
  assign fw_e = cfg.stop_clock[14];
  assign fh_e = cfg.stop_clock[15];
  assign fn_e = cfg.stop_clock[16];

  assign use_y = !cfg.start_date[21] && !cfg.stop_date[21] && (yr_s <= yr_e);
  assign use_m = !cfg.start_date[22] && !cfg.stop_date[22];
  assign use_d = !cfg.start_date[23] && !cfg.stop_date[23];
  assign use_h = !fh_s && !fh_e;
  assign use_n = !fn_s && !fn_e;

  // Date positions in days, counted as year*12*31 + month*31 + mday
  assign a12_s = 16'(use_y ? yr_s : 12'd0) * 16'(MONTHS_PER_YEAR)
               + 16'(use_m ? mo_s : 4'd0);
  assign a12_e = 16'(use_y ? yr_e : 12'd0) * 16'(MONTHS_PER_YEAR)
               + 16'(use_m ? mo_e : 4'd0);
  assign n12   = (use_y || use_m)
               ? 16'(use_y ? now_year : 12'd0) * 16'(MONTHS_PER_YEAR) + 16'(now_month)
               : 16'd0;

  assign sw = fw_s ? SPAN_ANY : $signed(SPAN_W'(wd_s));
  assign ew = fw_e ? SPAN_ANY : $signed(SPAN_W'(wd_e));
  assign day_full = span_test(sw, ew, $signed(SPAN_W'(now_wday)), WEEK_SPAN);

  // Continued mode: clock compare on the date boundary, one end only
  assign hs_a = fh_s ? 5'd0 : hr_s;
  assign hs_n = fh_s ? 5'd0 : now_hour;
  assign he_a = fh_e ? 5'd0 : hr_e;
  assign he_n = fh_e ? 5'd0 : now_hour;
  assign cs_a = fn_s ? MINC_W'(hs_a)
                     : MINC_W'(hs_a) * MINC_W'(MINUTES_PER_HOUR) + MINC_W'(mi_s);
  assign cs_n = fn_s ? MINC_W'(hs_n)
                     : MINC_W'(hs_n) * MINC_W'(MINUTES_PER_HOUR) + MINC_W'(now_minute);
  assign ce_a = fn_e ? MINC_W'(he_a)
                     : MINC_W'(he_a) * MINC_W'(MINUTES_PER_HOUR) + MINC_W'(mi_e);
  assign ce_n = fn_e ? MINC_W'(he_n)
                     : MINC_W'(he_n) * MINC_W'(MINUTES_PER_HOUR) + MINC_W'(now_minute);

  always_comb begin
    data_nxt.date_used    = use_y || use_m || use_d;
    data_nxt.da           = DATE_W'(a12_s) * DATE_W'(MDAYS_PER_MONTH)
                          + DATE_W'(use_d ? md_s : 5'd0);
    data_nxt.db           = DATE_W'(a12_e) * DATE_W'(MDAYS_PER_MONTH)
                          + DATE_W'(use_d ? md_e : 5'd0);
    data_nxt.dn           = DATE_W'(n12) * DATE_W'(MDAYS_PER_MONTH) + DATE_W'(now_mday);
    data_nxt.day_r        = DAYR_W'(day_full);
    data_nxt.week_both    = !fw_s && !fw_e;
    data_nxt.min_used     = use_h || use_n;
    data_nxt.ma           = MINC_W'(use_h ? hr_s : 5'd0) * MINC_W'(MINUTES_PER_HOUR)
                          + MINC_W'(use_n ? mi_s : 6'd0);
    data_nxt.mb           = MINC_W'(use_h ? hr_e : 5'd0) * MINC_W'(MINUTES_PER_HOUR)
                          + MINC_W'(use_n ? mi_e : 6'd0);
    data_nxt.mn           = MINC_W'(use_h ? now_hour : 5'd0) * MINC_W'(MINUTES_PER_HOUR)
                          + MINC_W'(now_minute);
    data_nxt.cd_start_hit = (!fh_s || !fn_s) && (cs_n >= cs_a);
    data_nxt.cd_stop_hit  = (!fh_e || !fn_e) && (ce_n < ce_a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* sv/swmts_span.sv */
// ----------------------------------------------------------------------------
// swmts_span
// Stage 2: date span test, hour:minute span test at now and one minute later,
// and the minute compares used by continued mode.
// ----------------------------------------------------------------------------
module swmts_span import swmts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic valid_in,
  input  s1_t  data_in,
  output logic valid_r,
  output s2_t  data_r
);

  logic signed [SPAN_W-1:0] date_full, min_full, min_full2;
  logic signed [SPAN_W-1:0] ma_s, mb_s, mn_s, mn1_s;
  s2_t data_nxt;

  assign ma_s  = $signed(SPAN_W'(data_in.ma));
  assign mb_s  = $signed(SPAN_W'(data_in.mb));
  assign mn_s  = $signed(SPAN_W'(data_in.mn));
  assign mn1_s = mn_s + SPAN_W'(1);

  assign date_full = data_in.date_used
                   ? span_test($signed(SPAN_W'(data_in.da)), $signed(SPAN_W'(data_in.db)),
                               $signed(SPAN_W'(data_in.dn)), DAY_SPAN)
                   : NO_CHECK;
  assign min_full  = span_test(ma_s, mb_s, mn_s, MIN_PER_DAY);
  assign min_full2 = span_test(ma_s, mb_s, mn1_s, MIN_PER_DAY);

  always_comb begin
    data_nxt.date_r       = DATER_W'(date_full);
    data_nxt.day_r        = data_in.day_r;
    data_nxt.week_both    = data_in.week_both;
    data_nxt.min_used     = data_in.min_used;
    data_nxt.min_r        = MINR_W'(min_full);
    data_nxt.min_r2       = MINR_W'(min_full2);
    data_nxt.ab_eq        = data_in.ma == data_in.mb;
    data_nxt.ab_lt        = data_in.ma < data_in.mb;
    data_nxt.n_lt_a       = data_in.mn < data_in.ma;
    data_nxt.n_gt_b       = data_in.mn > data_in.mb;
    data_nxt.a_minus_b    = $signed({1'b0, data_in.ma}) - $signed({1'b0, data_in.mb});
    data_nxt.tail         = MDIF_W'(MINUTES_PER_DAY) - $signed({1'b0, data_in.mb});
    data_nxt.cd_start_hit = data_in.cd_start_hit;
    data_nxt.cd_stop_hit  = data_in.cd_stop_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* sv/swmts_resolve.sv */
// ----------------------------------------------------------------------------
// swmts_resolve
// Stage 3: scale day distances to minutes, saturating the date distance, and pick the result
// in priority order date, weekday, hour:minute.
// ----------------------------------------------------------------------------
module swmts_resolve import swmts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_in,
  input  s2_t                     data_in,
  input  logic                    continued_mode,
  output logic                    valid_r,
  output logic signed [OUT_W-1:0] result_r
);

  logic [32:0]             date_prod;
  logic [OUT_W-1:0]        date_min, day_min;
  logic signed [OUT_W-1:0] wrap_val, late_val, result_nxt;
  logic date_pos, day_pos, min_pos, min2_pos;
  logic date_start, date_stop, day_start, day_stop;
  logic date_done, min_at_stop;

  assign date_pos   = !data_in.date_r[DATER_W-1] && (|data_in.date_r);
  assign day_pos    = !data_in.day_r[DAYR_W-1] && (|data_in.day_r);
  assign min_pos    = !data_in.min_r[MINR_W-1] && (|data_in.min_r);
  assign min2_pos   = !data_in.min_r2[MINR_W-1] && (|data_in.min_r2);
  assign date_start = data_in.date_r == DATER_W'(SPAN_AT_START);
  assign date_stop  = data_in.date_r == DATER_W'(SPAN_AT_STOP);
  assign day_start  = data_in.day_r == DAYR_W'(SPAN_AT_START);
  assign day_stop   = data_in.day_r == DAYR_W'(SPAN_AT_STOP);
  assign min_at_stop = data_in.min_r == MINR_W'(SPAN_AT_STOP)
                    || data_in.min_r == MINR_W'(SPAN_AT_BOTH);

  assign date_prod = 33'(data_in.date_r[DATER_W-2:0]) * 33'(MINUTES_PER_DAY);
  assign date_min  = (date_prod > 33'h07FFFFFFF) ? 32'h7FFFFFFF : date_prod[OUT_W-1:0];
  assign day_min   = OUT_W'(data_in.day_r[DAYR_W-2:0]) * OUT_W'(MINUTES_PER_DAY);
  assign wrap_val  = OUT_W'(data_in.min_r) + OUT_W'(data_in.a_minus_b);
  assign late_val  = OUT_W'(data_in.min_r2) + OUT_W'(1);

  // Window open across the date boundary in continued mode
  assign date_done = continued_mode
                  && (data_in.date_r == DATER_W'(SPAN_INSIDE)
                      || (date_start && data_in.cd_start_hit)
                      || (date_stop && data_in.cd_stop_hit));

  always_comb begin
    if (date_pos) begin
      result_nxt = $signed(date_min);
    end else if (date_done) begin
      result_nxt = '0;
    end else if (day_pos) begin
      result_nxt = $signed(day_min);
    end else if (continued_mode && data_in.day_r == DAYR_W'(SPAN_INSIDE)
                 && data_in.week_both) begin
      result_nxt = '0;
    end else if (!data_in.min_used || data_in.ab_eq) begin
      result_nxt = '0;
    end else if (continued_mode && data_in.ab_lt
                 && ((data_in.n_lt_a && (day_stop || date_stop))
                     || (data_in.n_gt_b && (day_start || date_start)))) begin
      result_nxt = '0;
    end else if (continued_mode && !data_in.ab_lt && data_in.n_lt_a
                 && (day_start || date_start)) begin
      result_nxt = wrap_val;
    end else if (continued_mode && !data_in.ab_lt && data_in.n_gt_b
                 && (day_stop || date_stop)) begin
      result_nxt = OUT_W'(data_in.tail);
    end else if (min_pos) begin
      result_nxt = OUT_W'(data_in.min_r);
    end else if (min_at_stop && min2_pos) begin
      result_nxt = late_val;
    end else begin
      result_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en && valid_in) begin
      result_r <= result_nxt;
    end
  end

endmodule

/* tb/window_minutes_checker.sv */
// ----------------------------------------------------------------------------
// window_minutes_checker
// Watches the register port and both item channels of the schedule window
// block. Keeps its own copy of the window registers, predicts the minutes to
// start for every accepted item and compares each accepted result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module window_minutes_checker import swmts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [PADDR_W-1:0]      cfg_paddr,
  input  logic [PDATA_W-1:0]      cfg_pwdata,
  input  logic                    cfg_pready,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [11:0]             in_now_year,
  input  logic [3:0]              in_now_month,
  input  logic [4:0]              in_now_mday,
  input  logic [2:0]              in_now_wday,
  input  logic [4:0]              in_now_hour,
  input  logic [5:0]              in_now_minute,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [OUT_W-1:0] out_minutes_to_start,
  output int                      errors,
  output int                      pending
);

  localparam longint ANY_FIELD   = -1;
  localparam longint POS_INSIDE  = 0;
  localparam longint POS_START   = -1;
  localparam longint POS_STOP    = -2;
  localparam longint POS_BOTH    = -3;
  localparam longint NO_DATE     = -4;
  localparam longint MIN_DAY     = 1440;
  localparam longint DAY_RANGE   = 1116000;
  localparam longint MONTH_RANGE = 36000;
  localparam longint YEAR_RANGE  = 3000;
  localparam longint MIN_HOUR    = 60;
  localparam longint HOUR_DAY    = 24;
  localparam longint WEEK_DAYS   = 7;
  localparam longint INT32_TOP   = 64'sd2147483647;
  localparam longint INT32_BOT   = -64'sd2147483648;

  cfg_t                    window_regs;
  logic signed [OUT_W-1:0] minutes_q[$];
  int                      fail_count = 0;

  assign errors = fail_count;

  function automatic longint comp_value(bit wild, longint v);
    return wild ? ANY_FIELD : v;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp32(longint v);
    if (v > INT32_TOP) v = INT32_TOP;
    if (v < INT32_BOT) v = INT32_BOT;
    return v[OUT_W-1:0];
  endfunction

  // Where n lies against a span s..e that wraps at m.
  function automatic longint span_pos(longint s, longint e, longint n, longint m);
    if (s == n && e == n) return POS_BOTH;
    if (s == n) return POS_START;
    if (e == n) return POS_STOP;
    if (s < 0 || e < 0) return POS_INSIDE;
    if (s < e) begin
      if (s < n && e > n) return POS_INSIDE;
      if (s < n && e < n) return m - n + s;
      return s - n;
    end
    if (s > e) begin
      if (s > n && e > n) return POS_INSIDE;
      if (s > n && e < n) return s - n;
      return POS_INSIDE;
    end
    if (s < n) return m - n + s;
    return s - n;
  endfunction

  function automatic logic signed [OUT_W-1:0] predict_minutes(
    cfg_t c, logic [11:0] yr_i, logic [3:0] mo_i, logic [4:0] md_i,
    logic [2:0] wd_i, logic [4:0] hr_i, logic [5:0] mi_i
  );
    longint yr, mo, md, wd, hr, mi;
    longint sy, sm, sd, ey, em, ed, sw, sh, sn, ew, eh, en;
    longint a, b, n, m, h, q, date_r, day_r, min_r;
    bit     cont, any;
    yr = longint'(yr_i);
    mo = longint'(mo_i);
    md = longint'(md_i);
    wd = longint'(wd_i);
    hr = longint'(hr_i);
    mi = longint'(mi_i);
    cont = c.continued_mode;
    sy = comp_value(c.start_date[21], longint'(c.start_date[11:0]));
    sm = comp_value(c.start_date[22], longint'(c.start_date[15:12]));
    sd = comp_value(c.start_date[23], longint'(c.start_date[20:16]));
    ey = comp_value(c.stop_date[21], longint'(c.stop_date[11:0]));
    em = comp_value(c.stop_date[22], longint'(c.stop_date[15:12]));
    ed = comp_value(c.stop_date[23], longint'(c.stop_date[20:16]));
    sw = comp_value(c.start_clock[14], longint'(c.start_clock[2:0]));
    sh = comp_value(c.start_clock[15], longint'(c.start_clock[7:3]));
    sn = comp_value(c.start_clock[16], longint'(c.start_clock[13:8]));
    ew = comp_value(c.stop_clock[14], longint'(c.stop_clock[2:0]));
    eh = comp_value(c.stop_clock[15], longint'(c.stop_clock[7:3]));
    en = comp_value(c.stop_clock[16], longint'(c.stop_clock[13:8]));

    a = 0;
    b = 0;
    n = 0;
    m = 0;
    date_r = NO_DATE;
    if (sy != ANY_FIELD && ey != ANY_FIELD && sy <= ey) begin
      a = sy;
      b = ey;
      n = yr;
      m = YEAR_RANGE;
    end
    if (sm != ANY_FIELD && em != ANY_FIELD) begin
      a = a * 12 + sm;
      b = b * 12 + em;
      n = n * 12 + mo;
      m = MONTH_RANGE;
    end else if (m != 0) begin
      a = a * 12;
      b = b * 12;
      n = n * 12 + mo;
      m = MONTH_RANGE;
    end
    if (sd != ANY_FIELD && ed != ANY_FIELD) begin
      a = a * 31 + sd;
      b = b * 31 + ed;
      n = n * 31 + md;
      m = DAY_RANGE;
    end else if (m != 0) begin
      a = a * 31;
      b = b * 31;
      n = n * 31 + md;
      m = DAY_RANGE;
    end

    if (m != 0) begin
      date_r = span_pos(a, b, n, m);
      if (date_r > 0) return clamp32(date_r * MIN_DAY);
      if (cont) begin
        if (date_r == POS_INSIDE) return 0;
        if (date_r == POS_START || date_r == POS_STOP) begin
          h = (date_r == POS_START) ? sh : eh;
          q = (date_r == POS_START) ? sn : en;
          any = 1'b0;
          a = 0;
          n = 0;
          if (h != ANY_FIELD) begin
            a = h;
            n = hr;
            any = 1'b1;
          end
          if (q != ANY_FIELD) begin
            a = a * MIN_HOUR + q;
            n = n * MIN_HOUR + mi;
            any = 1'b1;
          end
          if (any) begin
            if (date_r == POS_START && n >= a) return 0;
            if (date_r == POS_STOP && n < a) return 0;
          end
        end
      end
    end

    day_r = span_pos(sw, ew, wd, WEEK_DAYS);
    if (day_r > 0) return clamp32(day_r * MIN_DAY);
    if (cont && day_r == POS_INSIDE && sw != ANY_FIELD && ew != ANY_FIELD) return 0;

    a = 0;
    b = 0;
    n = 0;
    m = 0;
    if (sh != ANY_FIELD && eh != ANY_FIELD) begin
      a = sh;
      b = eh;
      n = hr;
      m = HOUR_DAY;
    end
    if (sn != ANY_FIELD && en != ANY_FIELD) begin
      a = a * MIN_HOUR + sn;
      b = b * MIN_HOUR + en;
      n = n * MIN_HOUR + mi;
      m = MIN_DAY;
    end else if (m != 0) begin
      a = a * MIN_HOUR;
      b = b * MIN_HOUR;
      n = n * MIN_HOUR + mi;
      m = MIN_DAY;
    end
    if (m == 0) return 0;
    if (a == b) return 0;

    min_r = span_pos(a, b, n, m);
    if (cont) begin
      if (a < b) begin
        if ((n < a && (day_r == POS_STOP || date_r == POS_STOP)) ||
            (n > b && (day_r == POS_START || date_r == POS_START)))
          return 0;
      end else begin
        if (n < a && (day_r == POS_START || date_r == POS_START))
          return clamp32(min_r + (a - b));
        else if (n > b && (day_r == POS_STOP || date_r == POS_STOP))
          return clamp32(MIN_DAY - b);
      end
    end
    if (min_r > 0) return clamp32(min_r);
    if (min_r == POS_START || min_r == POS_INSIDE) return 0;
    if (min_r == POS_STOP || min_r == POS_BOTH) begin
      // retry one minute past the stop point
      min_r = span_pos(a, b, n + 1, m);
      if (min_r > 0) return clamp32(min_r + 1);
    end
    if (min_r < 0) return 0;
    return clamp32(min_r);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    logic signed [OUT_W-1:0] want;
    if (!rst_n) begin
      window_regs.start_date     = DATE_RESET;
      window_regs.start_clock    = CLOCK_RESET;
      window_regs.stop_date      = DATE_RESET;
      window_regs.stop_clock     = CLOCK_RESET;
      window_regs.continued_mode = 1'b0;
      minutes_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        minutes_q.push_back(predict_minutes(window_regs, in_now_year, in_now_month,
                                            in_now_mday, in_now_wday, in_now_hour,
                                            in_now_minute));
      end
      if (out_valid && !out_stall) begin
        if (minutes_q.size() == 0) begin
          report_mismatch($sformatf("minutes_to_start %0d with no item outstanding",
                                    out_minutes_to_start));
        end else begin
          want = minutes_q.pop_front();
          if (out_minutes_to_start !== want) begin
            report_mismatch($sformatf("minutes_to_start expected %0d got %0d",
                                      want, out_minutes_to_start));
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_START_DATE:  window_regs.start_date     = cfg_pwdata[23:0];
          REG_START_CLOCK: window_regs.start_clock    = cfg_pwdata[16:0];
          REG_STOP_DATE:   window_regs.stop_date      = cfg_pwdata[23:0];
          REG_STOP_CLOCK:  window_regs.stop_clock     = cfg_pwdata[16:0];
          REG_CONTINUED:   window_regs.continued_mode = cfg_pwdata[0];
          default: ;
        endcase
      end
    end
    pending <= minutes_q.size();
  end

endmodule

/* tb/tb_schedule_window_minutes_to_start.sv */
// ----------------------------------------------------------------------------
// tb_schedule_window_minutes_to_start
// Drives the schedule window block through a directed set of windows and a
// long series of random windows, with items aimed at the window edges, random
// gaps on both channels and one long output hold. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_schedule_window_minutes_to_start import swmts_pkg::*;;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASES       = 26;
  localparam int PHASE_ITEMS  = 50;
  localparam int HOLD_CYCLES  = 200;
  localparam int LATENCY      = 3;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]      cfg_paddr = '0;
  logic [PDATA_W-1:0]      cfg_pwdata = '0;
  logic [PDATA_W-1:0]      cfg_prdata;
  logic                    cfg_pready;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [11:0]             in_now_year = '0;
  logic [3:0]              in_now_month = '0;
  logic [4:0]              in_now_mday = '0;
  logic [2:0]              in_now_wday = '0;
  logic [4:0]              in_now_hour = '0;
  logic [5:0]              in_now_minute = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_minutes_to_start;
  int                      errors;
  int                      pending;

  logic [23:0] cur_sd = DATE_RESET;
  logic [23:0] cur_ed = DATE_RESET;
  logic [16:0] cur_sc = CLOCK_RESET;
  logic [16:0] cur_ec = CLOCK_RESET;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  schedule_window_minutes_to_start uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_now_year          (in_now_year),
    .in_now_month         (in_now_month),
    .in_now_mday          (in_now_mday),
    .in_now_wday          (in_now_wday),
    .in_now_hour          (in_now_hour),
    .in_now_minute        (in_now_minute),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_minutes_to_start (out_minutes_to_start)
  );

  window_minutes_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_pready           (cfg_pready),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_now_year          (in_now_year),
    .in_now_month         (in_now_month),
    .in_now_mday          (in_now_mday),
    .in_now_wday          (in_now_wday),
    .in_now_hour          (in_now_hour),
    .in_now_minute        (in_now_minute),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_minutes_to_start (out_minutes_to_start),
    .errors               (errors),
    .pending              (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int draw_wait();
    if (no_idle) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [23:0] pack_date(bit any_y, bit any_mo, bit any_md,
                                            logic [11:0] yr, logic [3:0] mo,
                                            logic [4:0] md);
    return {any_md, any_mo, any_y, md, mo, yr};
  endfunction

  function automatic logic [16:0] pack_clock(bit any_w, bit any_h, bit any_mi,
                                             logic [2:0] wd, logic [4:0] hr,
                                             logic [5:0] mi);
    return {any_mi, any_h, any_w, mi, hr, wd};
  endfunction

  function automatic int nudge(int v, int lo, int hi);
    case ($urandom_range(0, 3))
      0, 1: return v;
      2: return v + int'($urandom_range(0, 2)) - 1;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic load_window(logic [23:0] sd, logic [16:0] sc, logic [23:0] ed,
                             logic [16:0] ec, bit cm);
    write_reg(REG_START_DATE, {8'd0, sd});
    write_reg(REG_START_CLOCK, {15'd0, sc});
    write_reg(REG_STOP_DATE, {8'd0, ed});
    write_reg(REG_STOP_CLOCK, {15'd0, ec});
    write_reg(REG_CONTINUED, {31'd0, cm});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_sd = sd;
    cur_sc = sc;
    cur_ed = ed;
    cur_ec = ec;
  endtask

  task automatic send_item(logic [11:0] yr, logic [3:0] mo, logic [4:0] md,
                           logic [2:0] wd, logic [4:0] hr, logic [5:0] mi);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_now_year   <= yr;
    in_now_month  <= mo;
    in_now_mday   <= md;
    in_now_wday   <= wd;
    in_now_hour   <= hr;
    in_now_minute <= mi;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_near();
    logic [23:0] d;
    logic [16:0] c;
    if ($urandom_range(0, 1) == 0) begin
      d = cur_sd;
      c = cur_sc;
    end else begin
      d = cur_ed;
      c = cur_ec;
    end
    send_item(12'(nudge(int'(d[11:0]), 0, 3000)), 4'(nudge(int'(d[15:12]), 0, 11)),
              5'(nudge(int'(d[20:16]), 1, 31)), 3'(nudge(int'(c[2:0]), 0, 6)),
              5'(nudge(int'(c[7:3]), 0, 23)), 6'(nudge(int'(c[13:8]), 0, 59)));
  endtask

  task automatic random_window();
    logic [23:0] sd, ed;
    logic [16:0] sc, ec;
    int          y0;
    int          y1;
    y0 = int'($urandom_range(1998, 2030));
    y1 = ($urandom_range(0, 1) == 1) ? y0 + int'($urandom_range(0, 2))
                                      : int'($urandom_range(1998, 2030));
    sd = pack_date($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                   $urandom_range(0, 2) == 0, 12'(y0), 4'($urandom_range(0, 11)),
                   5'($urandom_range(1, 31)));
    ed = pack_date($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                   $urandom_range(0, 2) == 0, 12'(y1),
                   4'($urandom_range(0, 11)), 5'($urandom_range(1, 31)));
    sc = pack_clock($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                    $urandom_range(0, 2) == 0, 3'($urandom_range(0, 6)),
                    5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
    ec = pack_clock($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                    $urandom_range(0, 2) == 0, 3'($urandom_range(0, 6)),
                    5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
    if ($urandom_range(0, 7) == 0) sd = 24'($urandom());
    if ($urandom_range(0, 7) == 0) ed = 24'($urandom());
    if ($urandom_range(0, 7) == 0) sc = 17'($urandom());
    if ($urandom_range(0, 7) == 0) ec = 17'($urandom());
    load_window(sd, sc, ed, ec, 1'($urandom_range(0, 1)));
  endtask

  // receiver: random stall per item, one long hold on request
  initial begin : receiver
    int  n;
    bit  hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int ph;
    int k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window: every field a wildcard, extremes of the inputs
    send_item(12'd0, 4'd0, 5'd0, 3'd0, 5'd0, 6'd0);
    send_item(12'hFFF, 4'hF, 5'h1F, 3'h7, 5'h1F, 6'h3F);

    // weekly slot Mon 09:00 to Fri 17:30
    wait_idle();
    load_window(DATE_RESET, pack_clock(1'b0, 1'b0, 1'b0, 3'd1, 5'd9, 6'd0),
                DATE_RESET, pack_clock(1'b0, 1'b0, 1'b0, 3'd5, 5'd17, 6'd30), 1'b0);
    send_item(12'd2024, 4'd4, 5'd5, 3'd0, 5'd8, 6'd0);
    send_item(12'd2024, 4'd4, 5'd6, 3'd1, 5'd9, 6'd0);
    send_item(12'd2024, 4'd4, 5'd8, 3'd3, 5'd12, 6'd0);
    send_item(12'd2024, 4'd4, 5'd10, 3'd5, 5'd17, 6'd30);
    send_item(12'd2024, 4'd4, 5'd11, 3'd6, 5'd10, 6'd0);
    send_item(12'd2024, 4'd4, 5'd6, 3'd1, 5'd8, 6'd59);

    // same start and stop time
    wait_idle();
    load_window(DATE_RESET, pack_clock(1'b1, 1'b0, 1'b0, 3'd0, 5'd10, 6'd0),
                DATE_RESET, pack_clock(1'b1, 1'b0, 1'b0, 3'd0, 5'd10, 6'd0), 1'b0);
    send_item(12'd2024, 4'd0, 5'd1, 3'd2, 5'd10, 6'd0);
    send_item(12'd2024, 4'd0, 5'd1, 3'd2, 5'd11, 6'd0);

    // year span in continued mode
    wait_idle();
    load_window(pack_date(1'b0, 1'b0, 1'b0, 12'd2020, 4'd2, 5'd1), CLOCK_RESET,
                pack_date(1'b0, 1'b0, 1'b0, 12'd2021, 4'd5, 5'd15), CLOCK_RESET, 1'b1);
    send_item(12'd2020, 4'd8, 5'd9, 3'd3, 5'd12, 6'd0);
    send_item(12'd2019, 4'd2, 5'd1, 3'd3, 5'd12, 6'd0);
    send_item(12'd2020, 4'd2, 5'd1, 3'd0, 5'd0, 6'd0);

    // year wildcard at one end, month and day set
    wait_idle();
    load_window(pack_date(1'b1, 1'b0, 1'b0, 12'd0, 4'd3, 5'd10),
                pack_clock(1'b1, 1'b0, 1'b0, 3'd0, 5'd8, 6'd0),
                pack_date(1'b0, 1'b0, 1'b0, 12'd2022, 4'd3, 5'd20),
                pack_clock(1'b1, 1'b0, 1'b1, 3'd0, 5'd9, 6'd0),
                1'b1);
    send_item(12'd2022, 4'd3, 5'd10, 3'd1, 5'd7, 6'd30);
    send_item(12'd2022, 4'd3, 5'd20, 3'd1, 5'd9, 6'd30);

    // saturation: date fields at their maxima, hour 31 out of range
    wait_idle();
    load_window(pack_date(1'b0, 1'b0, 1'b0, 12'hFFF, 4'hF, 5'h1F),
                pack_clock(1'b1, 1'b0, 1'b0, 3'd0, 5'd31, 6'd0),
                pack_date(1'b0, 1'b0, 1'b0, 12'hFFF, 4'hF, 5'h1F),
                pack_clock(1'b1, 1'b0, 1'b0, 3'd0, 5'd2, 6'd0),
                1'b0);
    send_item(12'd0, 4'd0, 5'd0, 3'd0, 5'd0, 6'd0);
    send_item(12'hFFF, 4'hF, 5'h1F, 3'd4, 5'd3, 6'd0);

    // continued span wrapping over the weekend
    wait_idle();
    load_window(DATE_RESET, pack_clock(1'b0, 1'b0, 1'b0, 3'd5, 5'd22, 6'd0),
                DATE_RESET, pack_clock(1'b0, 1'b0, 1'b0, 3'd1, 5'd6, 6'd0), 1'b1);
    send_item(12'd2024, 4'd1, 5'd2, 3'd5, 5'd21, 6'd0);
    send_item(12'd2024, 4'd1, 5'd5, 3'd1, 5'd7, 6'd0);
    send_item(12'd2024, 4'd1, 5'd3, 3'd6, 5'd3, 6'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      no_idle = (ph % 4 == 3);
      case (ph)
        0: load_window(24'h000000, 17'h00000, 24'h000000, 17'h00000, 1'b0);
        1: load_window(24'hFFFFFF, 17'h1FFFF, 24'hFFFFFF, 17'h1FFFF, 1'b1);
        2: load_window(24'h1FFFFF, 17'h03FFF, 24'h000000, 17'h00000, 1'b1);
        3: load_window(DATE_RESET, CLOCK_RESET, DATE_RESET, CLOCK_RESET, 1'b0);
        default: random_window();
      endcase
      if (ph == 5) begin
        no_idle = 1'b1;
        hold_req <= 1'b1;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9))
          0, 1: send_item(12'($urandom()), 4'($urandom()), 5'($urandom()),
                          3'($urandom()), 5'($urandom()), 6'($urandom()));
          2: send_item(12'($urandom_range(0, 3000)), 4'($urandom_range(0, 11)),
                       5'($urandom_range(1, 31)), 3'($urandom_range(0, 6)),
                       5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)));
          default: send_near();
        endcase
      end
    end

    wait_idle();
    repeat (LATENCY + 3) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** schedule_window_minutes_to_start: PASSED **");
    end else begin
      $display("** schedule_window_minutes_to_start: FAILED **");
    end
    $finish;
  end

  initial begin : limit
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("** schedule_window_minutes_to_start: FAILED **");
    $finish;
  end

endmodule
